### src/caar_pkg.sv
`timescale 1ns / 1ps
package caar_pkg;
	localparam int COORD_WIDTH_DEF = 32;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam logic signed [31:0] CORDIC_INV_GAIN = 32'sd652032874;
	localparam logic signed [31:0] RESET_MINUS_TEN = -32'sd655360;

	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_MOVE = 2'd1,
		OP_ROTATE = 2'd2,
		OP_ORBIT = 2'd3
	} opcode_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] turn_angle;
		logic signed [31:0] scaled_speed;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] cam_pos_x;
		logic signed [31:0] cam_pos_y;
		logic signed [31:0] cam_pos_z;
		logic signed [31:0] cam_view_x;
		logic signed [31:0] cam_view_y;
		logic signed [31:0] cam_view_z;
	} res_t;

	function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
		logic signed [33:0] r;
		unique case (i)
			5'd0: r = 34'sh020000000;
			5'd1: r = 34'sh012E4051E;
			5'd2: r = 34'sh009FB385B;
			5'd3: r = 34'sh0051111D4;
			5'd4: r = 34'sh0028B0D43;
			5'd5: r = 34'sh00145D7E1;
			5'd6: r = 34'sh000A2F61E;
			5'd7: r = 34'sh000517C55;
			5'd8: r = 34'sh00028BE53;
			5'd9: r = 34'sh000145F2F;
			5'd10: r = 34'sh0000A2F98;
			5'd11: r = 34'sh0000517CC;
			5'd12: r = 34'sh000028BE6;
			5'd13: r = 34'sh0000145F3;
			5'd14: r = 34'sh00000A2FA;
			5'd15: r = 34'sh00000517D;
			5'd16: r = 34'sh0000028BE;
			5'd17: r = 34'sh00000145F;
			5'd18: r = 34'sh000000A30;
			5'd19: r = 34'sh000000518;
			5'd20: r = 34'sh00000028C;
			5'd21: r = 34'sh000000146;
			5'd22: r = 34'sh0000000A3;
			5'd23: r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

### src/caar_if.sv
`timescale 1ns / 1ps
interface caar_cmd_if;
	logic valid;
	logic ready;
	caar_pkg::cmd_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface caar_res_if;
	logic valid;
	logic ready;
	caar_pkg::res_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### src/camera_axis_angle_rotator.sv
`timescale 1ns / 1ps
// Load goes from the transfer straight to the output state; move passes the move state first.
// Rotate and orbit: the time to the result is set by the
// CORDIC loop and the one shared multiplier that forms all 21 products in turn.
// One command at a time; the next is taken the cycle after the result transfer.
// arst_n low sets position and target to (0, -10, -10) and empties the result.
module camera_axis_angle_rotator #(
	parameter int COORD_WIDTH = caar_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = caar_pkg::CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	caar_cmd_if.sink cmd,
	caar_res_if.source res
);
	import caar_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int PW = (W > 34) ? W : 34;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CORDIC = 9'b000000010,
		ST_ROUND = 9'b000000100,
		ST_TAB = 9'b000001000,
		ST_TABB = 9'b000010000,
		ST_COEF = 9'b000100000,
		ST_VEC = 9'b001000000,
		ST_MOVE = 9'b010000000,
		ST_OUT = 9'b100000000
	} state_t;

	state_t state_q;
	cmd_t cmd_q;
	logic signed [W-1:0] pos_q [3];
	logic signed [W-1:0] tgt_q [3];
	logic signed [W-1:0] d_q [3];
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0] it_q;
	logic flip_q;
	logic signed [15:0] c_q, s_q;
	logic signed [33:0] ta_q [3];
	logic signed [33:0] pp_q [6];
	logic signed [31:0] sa_q [3];
	logic signed [19:0] m_q [9];
	logic [4:0] k_q;
	logic signed [W+17:0] acc_q;
	logic signed [W-1:0] r_q [3];
	logic res_valid_q;
	res_t res_q;

	logic signed [PW-1:0] mul_a, mul_b;
	logic signed [2*PW-1:0] mul_p;
	assign mul_p = mul_a * mul_b;

	logic signed [15:0] ax, ay, az;
	logic signed [17:0] tq;
	assign ax = cmd_q.axis_x;
	assign ay = cmd_q.axis_y;
	assign az = cmd_q.axis_z;
	assign tq = 18'sd16384 - 18'(c_q);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_TAB: begin
				mul_a = PW'(tq);
				unique case (k_q[2:0])
					3'd0: mul_b = PW'(ax);
					3'd1: mul_b = PW'(ay);
					3'd2: mul_b = PW'(az);
					default: mul_b = '0;
				endcase
			end
			ST_TABB: begin
				unique case (k_q[2:0])
					3'd0: begin mul_a = PW'(ta_q[0]); mul_b = PW'(ax); end
					3'd1: begin mul_a = PW'(ta_q[1]); mul_b = PW'(ay); end
					3'd2: begin mul_a = PW'(ta_q[2]); mul_b = PW'(az); end
					3'd3: begin mul_a = PW'(ta_q[0]); mul_b = PW'(ay); end
					3'd4: begin mul_a = PW'(ta_q[0]); mul_b = PW'(az); end
					3'd5: begin mul_a = PW'(ta_q[1]); mul_b = PW'(az); end
					default: ;
				endcase
			end
			ST_COEF: begin
				mul_a = PW'(s_q);
				unique case (k_q[1:0])
					2'd0: mul_b = PW'(ax);
					2'd1: mul_b = PW'(ay);
					default: mul_b = PW'(az);
				endcase
			end
			ST_VEC: begin
				mul_a = PW'(m_q[k_q[3:0]]);
				unique case (k_q[3:0])
					4'd0, 4'd3, 4'd6: mul_b = PW'(d_q[0]);
					4'd1, 4'd4, 4'd7: mul_b = PW'(d_q[1]);
					default: mul_b = PW'(d_q[2]);
				endcase
			end
			ST_MOVE: begin
				mul_a = PW'(k_q[0] ? d_q[2] : d_q[0]);
				mul_b = PW'(cmd_q.scaled_speed);
			end
			default: ;
		endcase
	end

	logic signed [33:0] dxs, dys;
	assign dxs = cx_q >>> it_q;
	assign dys = cy_q >>> it_q;

	function automatic logic signed [19:0] coef(input logic signed [33:0] q28);
		logic signed [33:0] v;
		v = q28 + 34'sd8192;
		return v[33:14];
	endfunction

	logic [31:0] z0;
	assign z0 = {cmd.data.turn_angle, 16'h0};

	assign cmd.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign res.valid = res_valid_q;
	assign res.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			pos_q[0] <= '0;
			pos_q[1] <= W'(RESET_MINUS_TEN);
			pos_q[2] <= W'(RESET_MINUS_TEN);
			tgt_q[0] <= '0;
			tgt_q[1] <= W'(RESET_MINUS_TEN);
			tgt_q[2] <= W'(RESET_MINUS_TEN);
			it_q <= '0;
			k_q <= '0;
		end else begin
			if (res.valid && res.ready) res_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						cmd_q <= cmd.data;
						k_q <= '0;
						it_q <= '0;
						acc_q <= '0;
						unique case (opcode_t'(cmd.data.opcode))
							OP_LOAD: begin
								pos_q[0] <= W'(cmd.data.vec_x);
								pos_q[1] <= W'(cmd.data.vec_y);
								pos_q[2] <= W'(cmd.data.vec_z);
								tgt_q[0] <= W'(cmd.data.point_x);
								tgt_q[1] <= W'(cmd.data.point_y);
								tgt_q[2] <= W'(cmd.data.point_z);
								state_q <= ST_OUT;
							end
							OP_MOVE: begin
								for (int i = 0; i < 3; i++) d_q[i] <= tgt_q[i] - pos_q[i];
								state_q <= ST_MOVE;
							end
							OP_ROTATE, OP_ORBIT: begin
								for (int i = 0; i < 3; i++) begin
									if (cmd.data.opcode == OP_ROTATE)
										d_q[i] <= tgt_q[i] - pos_q[i];
								end
								if (cmd.data.opcode == OP_ORBIT) begin
									d_q[0] <= pos_q[0] - W'(cmd.data.point_x);
									d_q[1] <= pos_q[1] - W'(cmd.data.point_y);
									d_q[2] <= pos_q[2] - W'(cmd.data.point_z);
								end
								cx_q <= 34'(CORDIC_INV_GAIN);
								cy_q <= '0;
								flip_q <= z0[31] ^ z0[30];
								cz_q <= 34'($signed(z0 + ((z0[31] ^ z0[30]) ?
									32'h80000000 : 32'h0)));
								state_q <= ST_CORDIC;
							end
							default: ;
						endcase
					end
				end
				ST_CORDIC: begin
					if (cz_q >= 0) begin
						cx_q <= cx_q - dys;
						cy_q <= cy_q + dxs;
						cz_q <= cz_q - atan_turn(it_q);
					end else begin
						cx_q <= cx_q + dys;
						cy_q <= cy_q - dxs;
						cz_q <= cz_q + atan_turn(it_q);
					end
					it_q <= it_q + 5'd1;
					if (32'(it_q) == CORDIC_STEPS - 1 || 32'(it_q) == ATAN_ENTRIES - 1)
						state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					c_q <= flip_q ? -16'((cx_q + 34'sd32768) >>> 16)
						: 16'((cx_q + 34'sd32768) >>> 16);
					s_q <= flip_q ? -16'((cy_q + 34'sd32768) >>> 16)
						: 16'((cy_q + 34'sd32768) >>> 16);
					state_q <= ST_TAB;
				end
				ST_TAB: begin
					ta_q[k_q[1:0]] <= 34'(mul_p);
					if (k_q == 5'd2) begin
						k_q <= '0;
						state_q <= ST_TABB;
					end else k_q <= k_q + 5'd1;
				end
				ST_TABB: begin
					pp_q[k_q[2:0]] <= 34'(mul_p >>> 14);
					if (k_q == 5'd5) begin
						k_q <= '0;
						state_q <= ST_COEF;
					end else k_q <= k_q + 5'd1;
				end
				ST_COEF: begin
					if (k_q == 5'd3) begin : coefs
						logic signed [33:0] cc;
						cc = {{4{c_q[15]}}, c_q, 14'd0};
						m_q[0] <= coef(cc + pp_q[0]);
						m_q[4] <= coef(cc + pp_q[1]);
						m_q[8] <= coef(cc + pp_q[2]);
						m_q[1] <= coef(pp_q[3] - 34'(sa_q[2]));
						m_q[3] <= coef(pp_q[3] + 34'(sa_q[2]));
						m_q[2] <= coef(pp_q[4] + 34'(sa_q[1]));
						m_q[6] <= coef(pp_q[4] - 34'(sa_q[1]));
						m_q[5] <= coef(pp_q[5] - 34'(sa_q[0]));
						m_q[7] <= coef(pp_q[5] + 34'(sa_q[0]));
						k_q <= '0;
						acc_q <= (W+18)'(8192);
						state_q <= ST_VEC;
					end else begin
						sa_q[k_q[1:0]] <= 32'(mul_p);
						k_q <= k_q + 5'd1;
					end
				end
				ST_VEC: begin
					begin : vacc
						logic signed [W+17:0] a;
						a = acc_q + (W+18)'(mul_p);
						if (k_q == 5'd2) r_q[0] <= W'(a >>> 14);
						if (k_q == 5'd5) r_q[1] <= W'(a >>> 14);
						if (k_q == 5'd8) r_q[2] <= W'(a >>> 14);
						if (k_q == 5'd2 || k_q == 5'd5) acc_q <= (W+18)'(8192);
						else acc_q <= a;
					end
					if (k_q == 5'd8) begin
						state_q <= ST_OUT;
						k_q <= 5'd16;
					end else k_q <= k_q + 5'd1;
				end
				ST_MOVE: begin
					begin : mv
						logic signed [W-1:0] m;
						m = W'((mul_p + (2*PW)'(32768)) >>> 16);
						pos_q[k_q[0] ? 2'd2 : 2'd0] <= pos_q[k_q[0] ? 2'd2 : 2'd0] + m;
						tgt_q[k_q[0] ? 2'd2 : 2'd0] <= tgt_q[k_q[0] ? 2'd2 : 2'd0] + m;
					end
					k_q <= k_q + 5'd1;
					if (k_q[0]) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (k_q == 5'd16) begin
						for (int i = 0; i < 3; i++) begin
							if (cmd_q.opcode == OP_ROTATE)
								tgt_q[i] <= pos_q[i] + r_q[i];
						end
						if (cmd_q.opcode == OP_ORBIT) begin
							pos_q[0] <= W'(cmd_q.point_x) + r_q[0];
							pos_q[1] <= W'(cmd_q.point_y) + r_q[1];
							pos_q[2] <= W'(cmd_q.point_z) + r_q[2];
						end
						k_q <= '0;
					end else begin
						res_q.cam_pos_x <= 32'(pos_q[0]);
						res_q.cam_pos_y <= 32'(pos_q[1]);
						res_q.cam_pos_z <= 32'(pos_q[2]);
						res_q.cam_view_x <= 32'(tgt_q[0]);
						res_q.cam_view_y <= 32'(tgt_q[1]);
						res_q.cam_view_z <= 32'(tgt_q[2]);
						res_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.ready) else $error("ready while busy");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> $stable(res_q)) else $error("result changed");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
endmodule
